>>> rtl/spea_pkg.sv
// ----------------------------------------------------------------------------
// spea_pkg
// Shared types, codes and defaults for the swap page extent allocator.
// ----------------------------------------------------------------------------
package spea_pkg;

	// default sizes
	localparam int FREE_ENTRIES_DEF  = 16;
	localparam int OWNER_ENTRIES_DEF = 16;
	localparam int PAGE_BITS_DEF     = 16;

	// total pages after reset
	localparam logic [15:0] TOTAL_PAGES_RST = 16'd1024;

	// command codes
	localparam logic [2:0] FUNC_ALLOC    = 3'd0;
	localparam logic [2:0] FUNC_LOOKUP   = 3'd1;
	localparam logic [2:0] FUNC_TOTAL    = 3'd2;
	localparam logic [2:0] FUNC_COMPACT  = 3'd3;
	localparam logic [2:0] FUNC_COALESCE = 3'd4;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NOFIT = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// command transaction
	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] owner_id;
		logic [15:0] page_count;
	} in_t;

	// result transaction
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] start_page;
		logic [15:0] free_pages;
	} out_t;

	// controls for the free extent cell row
	typedef struct packed {
		logic shift;     // every cell takes its right neighbor, last takes din
		logic sort;      // one odd-even transposition round
		logic phase;     // pair parity of the round
		logic by_start;  // sort key includes the extent start
		logic clr;       // cell zero loads din, the rest empty out
		logic app;       // first empty cell loads din
	} free_op_t;

	// controls for the owner cell row
	typedef struct packed {
		logic shift;
		logic wr;
	} owner_op_t;

	// sort key compare: empty cells order after filled ones
	function automatic logic key_gt(input logic a_vld, input logic b_vld,
			input logic a_start_gt, input logic by_start);
		key_gt = (!a_vld && b_vld) || (by_start && a_vld && b_vld && a_start_gt);
	endfunction

endpackage

>>> rtl/spea_free_cell.sv
// ----------------------------------------------------------------------------
// spea_free_cell
// One free extent slot of the free table row: shift, sort and load steps.
// ----------------------------------------------------------------------------
module spea_free_cell #(
	parameter int PAGE_BITS = spea_pkg::PAGE_BITS_DEF,
	parameter int IDX       = 0,
	parameter int ENTRIES   = spea_pkg::FREE_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spea_pkg::free_op_t   op,
	input  logic                 left_vld,
	input  logic [PAGE_BITS-1:0] left_start,
	input  logic [PAGE_BITS-1:0] left_len,
	input  logic                 right_vld,
	input  logic [PAGE_BITS-1:0] right_start,
	input  logic [PAGE_BITS-1:0] right_len,
	input  logic                 din_vld,
	input  logic [PAGE_BITS-1:0] din_start,
	input  logic [PAGE_BITS-1:0] din_len,
	output logic                 vld,
	output logic [PAGE_BITS-1:0] start,
	output logic [PAGE_BITS-1:0] len
);
	import spea_pkg::*;

	localparam bit   HAS_L   = (IDX > 0);
	localparam bit   HAS_R   = (IDX < ENTRIES - 1);
	localparam logic ODD     = 1'(IDX % 2);
	localparam logic [PAGE_BITS-1:0] RST_LEN = PAGE_BITS'(TOTAL_PAGES_RST);

	logic vld_q;
	logic [PAGE_BITS-1:0] start_q, len_q;
	logic take_r, take_l;

	// transposition pair decisions
	always_comb begin
		take_r = op.sort && HAS_R && (op.phase == ODD) &&
			key_gt(vld_q, right_vld, start_q > right_start, op.by_start);
		take_l = op.sort && HAS_L && (op.phase != ODD) &&
			key_gt(left_vld, vld_q, left_start > start_q, op.by_start);
	end

	// slot register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= (IDX == 0);
			start_q <= '0;
			len_q   <= (IDX == 0) ? RST_LEN : '0;
		end else if (op.clr) begin
			vld_q   <= (IDX == 0) ? din_vld : 1'b0;
			start_q <= din_start;
			len_q   <= din_len;
		end else if (op.shift) begin
			vld_q   <= right_vld;
			start_q <= right_start;
			len_q   <= right_len;
		end else if (take_r) begin
			vld_q   <= right_vld;
			start_q <= right_start;
			len_q   <= right_len;
		end else if (take_l) begin
			vld_q   <= left_vld;
			start_q <= left_start;
			len_q   <= left_len;
		end else if (op.app && !vld_q && (!HAS_L || left_vld)) begin
			vld_q   <= din_vld;
			start_q <= din_start;
			len_q   <= din_len;
		end
	end

	assign vld   = vld_q;
	assign start = start_q;
	assign len   = len_q;

endmodule

>>> rtl/spea_owner_cell.sv
// ----------------------------------------------------------------------------
// spea_owner_cell
// One owner record slot of the owner table row: shift and write.
// ----------------------------------------------------------------------------
module spea_owner_cell #(
	parameter int PAGE_BITS = spea_pkg::PAGE_BITS_DEF
) (
	input  logic                 clk,
	input  spea_pkg::owner_op_t  op,
	input  logic                 sel,
	input  logic [15:0]          nxt_tag,
	input  logic [PAGE_BITS-1:0] nxt_start,
	input  logic [15:0]          nxt_len,
	input  logic [15:0]          din_tag,
	input  logic [PAGE_BITS-1:0] din_start,
	input  logic [15:0]          din_len,
	output logic [15:0]          tag,
	output logic [PAGE_BITS-1:0] start,
	output logic [15:0]          len
);
	import spea_pkg::*;

	logic [15:0]          tag_q, len_q;
	logic [PAGE_BITS-1:0] start_q;

	// record register, contents undefined until written
	always_ff @(posedge clk) begin
		if (op.shift) begin
			tag_q   <= nxt_tag;
			start_q <= nxt_start;
			len_q   <= nxt_len;
		end else if (op.wr && sel) begin
			tag_q   <= din_tag;
			start_q <= din_start;
			len_q   <= din_len;
		end
	end

	assign tag   = tag_q;
	assign start = start_q;
	assign len   = len_q;

endmodule

>>> rtl/swap_page_extent_allocator.sv
// ----------------------------------------------------------------------------
// swap_page_extent_allocator
// First-fit free extent allocator with an owner table, built as two rows
// of cells that rotate through a head slot under a command sequencer.
// ----------------------------------------------------------------------------
//  channel   | signals                       | transaction
//  command   | in_valid, in_stall, in_data   | func, owner_id, page_count
//  result    | out_valid, out_stall, out_data| status, start_page, free_pages
//  config    | cfg_we, cfg_wdata             | total_pages
//
//  With F free slots: allocate scans the free row, packs it and writes
//  the owner record, stopping after the scan when nothing fits and at
//  once on a full owner table; coalesce sorts, merges and packs the row;
//  each pass walks a cell row one slot per cycle or runs F transposition
//  rounds. One command is worked at a time; the result register lets the
//  next command start while a result waits. Reset leaves one free extent
//  of 1024 pages at page zero and an empty owner table.
module swap_page_extent_allocator #(
	parameter int FREE_ENTRIES  = spea_pkg::FREE_ENTRIES_DEF,
	parameter int OWNER_ENTRIES = spea_pkg::OWNER_ENTRIES_DEF,
	parameter int PAGE_BITS     = spea_pkg::PAGE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  spea_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output spea_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata
);
	import spea_pkg::*;

	localparam int MAXE = (FREE_ENTRIES > OWNER_ENTRIES) ? FREE_ENTRIES : OWNER_ENTRIES;
	localparam int CW   = $clog2(MAXE + 2);
	localparam int OCW  = $clog2(OWNER_ENTRIES + 1);
	localparam int CMPW = (PAGE_BITS > 16) ? PAGE_BITS : 16;
	localparam int SW   = CMPW + 1;
	localparam int EW   = PAGE_BITS + 1;
	localparam int POSW = 16 + OCW;
	localparam logic [SW-1:0] SUM_LIM = SW'(65536);

	typedef enum logic [3:0] {
		S_IDLE, S_AL_SCAN, S_AL_PACK, S_AL_APP, S_LK_SCAN, S_SUM_SCAN,
		S_CP_SCAN, S_CP_FIN, S_CO_SORT, S_CO_MERGE, S_CO_PACK, S_FIN
	} state_t;

	state_t               st_q;
	logic [CW-1:0]        cnt_q;
	logic [OCW-1:0]       owner_cnt_q;
	logic [15:0]          total_q;
	in_t                  cmd_q;
	logic                 found_q;
	logic [PAGE_BITS-1:0] res_start_q;
	logic                 rem_vld_q;
	logic [PAGE_BITS-1:0] rem_start_q, rem_len_q;
	logic [SW-1:0]        acc_q;
	logic [POSW-1:0]      pos_q;
	logic                 m_vld_q;
	logic [PAGE_BITS-1:0] m_start_q, m_len_q;
	logic [EW-1:0]        m_end_q;
	logic [1:0]           status_q;
	logic [15:0]          res16_q, free16_q;
	logic                 out_valid_q;
	out_t                 out_data_q;

	// cell rows
	logic                 f_vld   [FREE_ENTRIES];
	logic [PAGE_BITS-1:0] f_start [FREE_ENTRIES];
	logic [PAGE_BITS-1:0] f_len   [FREE_ENTRIES];
	logic                 lv [FREE_ENTRIES];
	logic [PAGE_BITS-1:0] ls [FREE_ENTRIES];
	logic [PAGE_BITS-1:0] ll [FREE_ENTRIES];
	logic                 rv [FREE_ENTRIES];
	logic [PAGE_BITS-1:0] rs [FREE_ENTRIES];
	logic [PAGE_BITS-1:0] rl [FREE_ENTRIES];
	logic [15:0]          o_tag   [OWNER_ENTRIES];
	logic [PAGE_BITS-1:0] o_start [OWNER_ENTRIES];
	logic [15:0]          o_len   [OWNER_ENTRIES];
	logic [15:0]          on_tag   [OWNER_ENTRIES];
	logic [PAGE_BITS-1:0] on_start [OWNER_ENTRIES];
	logic [15:0]          on_len   [OWNER_ENTRIES];

	free_op_t             fop;
	owner_op_t            oop;
	logic                 fd_vld;
	logic [PAGE_BITS-1:0] fd_start, fd_len;
	logic [15:0]          od_tag, od_len;
	logic [PAGE_BITS-1:0] od_start;

	logic                 h_vld;
	logic [PAGE_BITS-1:0] h_start, h_len;
	logic                 fit, idx_ok, match, cont;
	logic                 last_free, last_merge, last_own;
	logic [SW:0]          sum_w;
	logic [SW-1:0]        acc_nxt;
	logic [POSW-1:0]      tot_ext;
	logic [EW-1:0]        h_end;

	assign h_vld   = f_vld[0];
	assign h_start = f_start[0];
	assign h_len   = f_len[0];

	// head decisions
	always_comb begin
		last_free  = (cnt_q == CW'(FREE_ENTRIES - 1));
		last_merge = (cnt_q == CW'(FREE_ENTRIES));
		last_own   = (cnt_q == CW'(OWNER_ENTRIES - 1));
		fit    = (st_q == S_AL_SCAN) && h_vld && !found_q &&
			(CMPW'(h_len) >= CMPW'(cmd_q.page_count));
		idx_ok = (CW'(owner_cnt_q) > cnt_q);
		match  = (st_q == S_LK_SCAN) && idx_ok && !found_q &&
			(o_tag[0] == cmd_q.owner_id);
		h_end  = EW'(h_start) + EW'(h_len);
		cont   = m_vld_q && h_vld && (m_end_q == EW'(h_start));
		sum_w  = (SW + 1)'(acc_q) + (SW + 1)'(h_len);
		if (!h_vld)
			acc_nxt = acc_q;
		else if (sum_w > (SW + 1)'(SUM_LIM))
			acc_nxt = SUM_LIM;
		else
			acc_nxt = SW'(sum_w);
		tot_ext = POSW'(total_q);
	end

	// row controls
	always_comb begin
		fop          = '0;
		fop.shift    = (st_q == S_AL_SCAN) || (st_q == S_SUM_SCAN) || (st_q == S_CO_MERGE);
		fop.sort     = (st_q == S_AL_PACK) || (st_q == S_CO_SORT) || (st_q == S_CO_PACK);
		fop.phase    = cnt_q[0];
		fop.by_start = (st_q == S_CO_SORT);
		fop.clr      = (st_q == S_CP_FIN);
		fop.app      = (st_q == S_AL_APP);
		oop.shift    = (st_q == S_LK_SCAN) || (st_q == S_CP_SCAN);
		oop.wr       = (st_q == S_AL_APP);
	end

	// free row input
	always_comb begin
		fd_vld   = h_vld;
		fd_start = h_start;
		fd_len   = h_len;
		case (st_q)
			S_AL_SCAN: begin
				if (fit)
					fd_vld = 1'b0;
			end
			S_AL_APP: begin
				fd_vld   = rem_vld_q;
				fd_start = rem_start_q;
				fd_len   = rem_len_q;
			end
			S_CP_FIN: begin
				fd_vld   = (pos_q < tot_ext);
				fd_start = PAGE_BITS'(pos_q);
				fd_len   = PAGE_BITS'(tot_ext - pos_q);
			end
			S_CO_MERGE: begin
				if (cont) begin
					fd_vld = 1'b0;
				end else begin
					fd_vld   = m_vld_q;
					fd_start = m_start_q;
					fd_len   = m_len_q;
				end
			end
			default: ;
		endcase
	end

	// owner row input
	always_comb begin
		od_tag   = o_tag[0];
		od_start = o_start[0];
		od_len   = o_len[0];
		case (st_q)
			S_CP_SCAN: begin
				if (idx_ok)
					od_start = PAGE_BITS'(pos_q);
			end
			S_AL_APP: begin
				od_tag   = cmd_q.owner_id;
				od_start = res_start_q;
				od_len   = cmd_q.page_count;
			end
			default: ;
		endcase
	end

	// free extent cells
	for (genvar i = 0; i < FREE_ENTRIES; i++) begin : g_free
		if (i == 0) begin : g_l0
			assign lv[i] = 1'b0;
			assign ls[i] = '0;
			assign ll[i] = '0;
		end else begin : g_ln
			assign lv[i] = f_vld[i-1];
			assign ls[i] = f_start[i-1];
			assign ll[i] = f_len[i-1];
		end
		if (i == FREE_ENTRIES - 1) begin : g_rl
			assign rv[i] = fd_vld;
			assign rs[i] = fd_start;
			assign rl[i] = fd_len;
		end else begin : g_rn
			assign rv[i] = f_vld[i+1];
			assign rs[i] = f_start[i+1];
			assign rl[i] = f_len[i+1];
		end
		spea_free_cell #(
			.PAGE_BITS (PAGE_BITS),
			.IDX       (i),
			.ENTRIES   (FREE_ENTRIES)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (fop),
			.left_vld    (lv[i]),
			.left_start  (ls[i]),
			.left_len    (ll[i]),
			.right_vld   (rv[i]),
			.right_start (rs[i]),
			.right_len   (rl[i]),
			.din_vld     (fd_vld),
			.din_start   (fd_start),
			.din_len     (fd_len),
			.vld         (f_vld[i]),
			.start       (f_start[i]),
			.len         (f_len[i])
		);
	end

	// owner record cells
	for (genvar i = 0; i < OWNER_ENTRIES; i++) begin : g_own
		if (i == OWNER_ENTRIES - 1) begin : g_nl
			assign on_tag[i]   = od_tag;
			assign on_start[i] = od_start;
			assign on_len[i]   = od_len;
		end else begin : g_nn
			assign on_tag[i]   = o_tag[i+1];
			assign on_start[i] = o_start[i+1];
			assign on_len[i]   = o_len[i+1];
		end
		spea_owner_cell #(
			.PAGE_BITS (PAGE_BITS)
		) u_cell (
			.clk       (clk),
			.op        (oop),
			.sel       (owner_cnt_q == OCW'(i)),
			.nxt_tag   (on_tag[i]),
			.nxt_start (on_start[i]),
			.nxt_len   (on_len[i]),
			.din_tag   (od_tag),
			.din_start (od_start),
			.din_len   (od_len),
			.tag       (o_tag[i]),
			.start     (o_start[i]),
			.len       (o_len[i])
		);
	end

	// command sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			cnt_q       <= '0;
			owner_cnt_q <= '0;
			total_q     <= TOTAL_PAGES_RST;
			cmd_q       <= '0;
			found_q     <= 1'b0;
			res_start_q <= '0;
			rem_vld_q   <= 1'b0;
			rem_start_q <= '0;
			rem_len_q   <= '0;
			acc_q       <= '0;
			pos_q       <= '0;
			m_vld_q     <= 1'b0;
			m_start_q   <= '0;
			m_len_q     <= '0;
			m_end_q     <= '0;
			status_q    <= STAT_OK;
			res16_q     <= '0;
			free16_q    <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (cfg_we)
				total_q <= cfg_wdata;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q    <= in_data;
						cnt_q    <= '0;
						found_q  <= 1'b0;
						acc_q    <= '0;
						pos_q    <= '0;
						m_vld_q  <= 1'b0;
						status_q <= STAT_OK;
						res16_q  <= '0;
						free16_q <= '0;
						case (in_data.func)
							FUNC_ALLOC: begin
								if (owner_cnt_q == OCW'(OWNER_ENTRIES)) begin
									status_q <= STAT_FULL;
									st_q     <= S_FIN;
								end else begin
									st_q <= S_AL_SCAN;
								end
							end
							FUNC_LOOKUP:   st_q <= S_LK_SCAN;
							FUNC_TOTAL:    st_q <= S_SUM_SCAN;
							FUNC_COMPACT:  st_q <= S_CP_SCAN;
							FUNC_COALESCE: st_q <= S_CO_SORT;
							default:       st_q <= S_FIN;
						endcase
					end
				end
				S_AL_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (fit) begin
						found_q     <= 1'b1;
						res_start_q <= h_start;
						res16_q     <= 16'(h_start);
						rem_start_q <= PAGE_BITS'(CMPW'(h_start) + CMPW'(cmd_q.page_count));
						rem_len_q   <= PAGE_BITS'(CMPW'(h_len) - CMPW'(cmd_q.page_count));
						rem_vld_q   <= (CMPW'(h_len) != CMPW'(cmd_q.page_count));
					end
					if (last_free) begin
						cnt_q <= '0;
						if (found_q || fit) begin
							st_q <= S_AL_PACK;
						end else begin
							status_q <= STAT_NOFIT;
							st_q     <= S_FIN;
						end
					end
				end
				S_AL_PACK: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_free) begin
						cnt_q <= '0;
						st_q  <= S_AL_APP;
					end
				end
				S_AL_APP: begin
					owner_cnt_q <= owner_cnt_q + 1'b1;
					st_q        <= S_FIN;
				end
				S_LK_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (match) begin
						found_q <= 1'b1;
						res16_q <= 16'(o_start[0]);
					end
					if (last_own) begin
						cnt_q    <= '0;
						status_q <= (found_q || match) ? STAT_OK : STAT_NOFIT;
						st_q     <= S_FIN;
					end
				end
				S_SUM_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					acc_q <= acc_nxt;
					if (last_free) begin
						cnt_q    <= '0;
						free16_q <= (acc_nxt == SUM_LIM) ? 16'hFFFF : 16'(acc_nxt);
						st_q     <= S_FIN;
					end
				end
				S_CP_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (idx_ok)
						pos_q <= pos_q + POSW'(o_len[0]);
					if (last_own) begin
						cnt_q <= '0;
						st_q  <= S_CP_FIN;
					end
				end
				S_CP_FIN: begin
					res16_q <= (pos_q > POSW'(16'hFFFF)) ? 16'hFFFF : 16'(pos_q);
					st_q    <= S_FIN;
				end
				S_CO_SORT: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_free) begin
						cnt_q   <= '0;
						m_vld_q <= 1'b0;
						st_q    <= S_CO_MERGE;
					end
				end
				S_CO_MERGE: begin
					cnt_q   <= cnt_q + 1'b1;
					m_end_q <= h_end;
					if (cont) begin
						m_len_q <= m_len_q + h_len;
					end else begin
						m_vld_q   <= h_vld;
						m_start_q <= h_start;
						m_len_q   <= h_len;
					end
					if (last_merge) begin
						cnt_q <= '0;
						st_q  <= S_CO_PACK;
					end
				end
				S_CO_PACK: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_free) begin
						cnt_q <= '0;
						st_q  <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q           <= 1'b1;
						out_data_q.status     <= status_q;
						out_data_q.start_page <= res16_q;
						out_data_q.free_pages <= free16_q;
						st_q                  <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (st_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> rtl/spea_chk.sv
// ----------------------------------------------------------------------------
// spea_chk
// Port-level checks on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module spea_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input spea_pkg::out_t out_data
);
	import spea_pkg::*;

	// one command in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("command accepted while another is in work");

	// a result appears only from a command in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a command in work");

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// status stays within its codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == STAT_OK || out_data.status == STAT_NOFIT ||
			out_data.status == STAT_FULL))
		else $error("bad status code");

endmodule

bind swap_page_extent_allocator spea_chk u_spea_chk (.*);

>>> verif/spea_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spea_checker
// Watches the command, result and config ports of the extent allocator,
// keeps its own copy of the free and owner tables, predicts each result
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module spea_checker
	import spea_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_t         in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_t        out_data,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output int          pending,
	output int          errors
);

	localparam int NF = FREE_ENTRIES_DEF;
	localparam int NO = OWNER_ENTRIES_DEF;

	// shadow allocator state
	logic [15:0] area_pages;
	logic [15:0] fr_start [NF];
	logic [15:0] fr_len [NF];
	int          fr_cnt;
	logic [15:0] own_tag [NO];
	logic [15:0] own_start [NO];
	logic [15:0] own_len [NO];
	int          own_cnt;

	out_t results_due [$];

	assign pending = results_due.size();

	// apply one command to the shadow tables and return its result
	function automatic out_t run_command(in_t cmd);
		out_t        r;
		logic [15:0] s, l, rest;
		logic [16:0] span_end;
		int          pos, sum, i, j, n;
		logic [31:0] len;
		r = '0;
		case (cmd.func)
			FUNC_ALLOC: begin
				if (own_cnt >= NO) begin
					r.status = STAT_FULL;
				end else begin
					r.status = STAT_NOFIT;
					for (i = 0; i < fr_cnt; i++) begin
						if (fr_len[i] >= cmd.page_count) begin
							s = fr_start[i];
							rest = fr_len[i] - cmd.page_count;
							for (j = i; j + 1 < fr_cnt; j++) begin
								fr_start[j] = fr_start[j+1];
								fr_len[j] = fr_len[j+1];
							end
							fr_cnt--;
							if (rest != 0) begin
								fr_start[fr_cnt] = s + cmd.page_count;
								fr_len[fr_cnt] = rest;
								fr_cnt++;
							end
							own_tag[own_cnt] = cmd.owner_id;
							own_start[own_cnt] = s;
							own_len[own_cnt] = cmd.page_count;
							own_cnt++;
							r.status = STAT_OK;
							r.start_page = s;
							break;
						end
					end
				end
			end
			FUNC_LOOKUP: begin
				r.status = STAT_NOFIT;
				for (i = 0; i < own_cnt; i++) begin
					if (own_tag[i] == cmd.owner_id) begin
						r.status = STAT_OK;
						r.start_page = own_start[i];
						break;
					end
				end
			end
			FUNC_TOTAL: begin
				sum = 0;
				for (i = 0; i < fr_cnt; i++)
					sum += fr_len[i];
				r.free_pages = (sum > 65535) ? 16'hffff : sum[15:0];
			end
			FUNC_COMPACT: begin
				pos = 0;
				for (i = 0; i < own_cnt; i++) begin
					own_start[i] = pos[15:0];
					pos += own_len[i];
				end
				if (pos < int'(area_pages)) begin
					fr_start[0] = pos[15:0];
					fr_len[0] = area_pages - pos[15:0];
					fr_cnt = 1;
				end else begin
					fr_cnt = 0;
				end
				r.start_page = (pos > 65535) ? 16'hffff : pos[15:0];
			end
			FUNC_COALESCE: begin
				// stable insertion sort by start
				for (i = 1; i < fr_cnt; i++) begin
					s = fr_start[i];
					l = fr_len[i];
					j = i;
					while (j > 0 && fr_start[j-1] > s) begin
						fr_start[j] = fr_start[j-1];
						fr_len[j] = fr_len[j-1];
						j--;
					end
					fr_start[j] = s;
					fr_len[j] = l;
				end
				// merge touching neighbors
				i = 0;
				n = 0;
				while (i < fr_cnt) begin
					s = fr_start[i];
					len = fr_len[i];
					span_end = {1'b0, fr_start[i]} + fr_len[i];
					i++;
					while (i < fr_cnt && span_end == {1'b0, fr_start[i]}) begin
						len += fr_len[i];
						span_end = {1'b0, fr_start[i]} + fr_len[i];
						i++;
					end
					fr_start[n] = s;
					fr_len[n] = len[15:0];
					n++;
				end
				fr_cnt = n;
			end
			default: ;
		endcase
		return r;
	endfunction

	// track transactions on every port
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			area_pages = TOTAL_PAGES_RST;
			fr_start[0] = '0;
			fr_len[0] = TOTAL_PAGES_RST;
			fr_cnt = 1;
			own_cnt = 0;
			errors = 0;
			results_due.delete();
		end else begin
			if (cfg_we)
				area_pages = cfg_wdata;
			if (in_valid && !in_stall)
				results_due.push_back(run_command(in_data));
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					errors++;
				end else begin
					want = results_due.pop_front();
					if (out_data.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, out_data.status);
						errors++;
					end
					if (out_data.start_page !== want.start_page) begin
						$display("%0t: start_page expected %0d actual %0d",
							$time, want.start_page, out_data.start_page);
						errors++;
					end
					if (out_data.free_pages !== want.free_pages) begin
						$display("%0t: free_pages expected %0d actual %0d",
							$time, want.free_pages, out_data.free_pages);
						errors++;
					end
				end
			end
		end
	end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the swap page extent allocator: directed commands, then
// random phases under several area sizes, with random idling on both
// channels and one long receiver hold-off; a checker predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
	import spea_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_t         in_data;
	logic        out_valid;
	logic        out_stall;
	out_t        out_data;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	int          pending;
	int          errors;
	int          cycles;
	int          sent;
	logic [15:0] known_owners [$];

	swap_page_extent_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	spea_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.pending(pending), .errors(errors)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// cycle limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off, a calm stretch, then random stalls again
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		repeat (3000) begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < 9);
		end
		@(negedge clk);
		out_stall <= 1'b1;
		repeat (600) @(negedge clk);
		out_stall <= 1'b0;
		repeat (2000) @(negedge clk);
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < 9);
		end
	end

	// offer one command and wait for its transaction
	task automatic send_cmd(logic [2:0] f, logic [15:0] who, logic [15:0] cnt);
		bit calm;
		calm = (sent >= 150 && sent < 350);
		while (!calm && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{func: f, owner_id: who, page_count: cnt};
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (f == FUNC_ALLOC)
			known_owners.push_back(who);
		sent++;
	endtask

	// drain, then write the area size
	task automatic set_area(logic [15:0] pages);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= pages;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_cmd();
		int          pick;
		logic [2:0]  f;
		logic [15:0] who, cnt;
		pick = $urandom_range(99);
		if (pick < 30) f = FUNC_ALLOC;
		else if (pick < 50) f = FUNC_LOOKUP;
		else if (pick < 65) f = FUNC_TOTAL;
		else if (pick < 73) f = FUNC_COMPACT;
		else if (pick < 90) f = FUNC_COALESCE;
		else f = 3'($urandom_range(7, 5));
		who = 16'($urandom());
		if (f == FUNC_LOOKUP && known_owners.size() != 0 && $urandom_range(1))
			who = known_owners[$urandom_range(known_owners.size() - 1)];
		pick = $urandom_range(99);
		if (pick < 70) cnt = 16'($urandom_range(64, 1));
		else if (pick < 92) cnt = 16'($urandom());
		else cnt = '0;
		send_cmd(f, who, cnt);
	endtask

	// stimulus and verdict
	initial begin
		logic [15:0] areas [4] = '{16'd65535, 16'd1, 16'd40000, 16'd2000};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sent = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed commands against the reset area
		send_cmd(FUNC_LOOKUP, 16'h0000, 16'd1);
		send_cmd(FUNC_TOTAL, 16'hffff, 16'hffff);
		send_cmd(FUNC_ALLOC, 16'h0000, 16'd0);
		send_cmd(FUNC_ALLOC, 16'hffff, 16'hffff);
		send_cmd(FUNC_ALLOC, 16'hffff, 16'd1);
		send_cmd(FUNC_ALLOC, 16'h1234, 16'd100);
		send_cmd(FUNC_ALLOC, 16'h5678, 16'd923);
		send_cmd(FUNC_ALLOC, 16'h9abc, 16'd1);
		send_cmd(FUNC_LOOKUP, 16'hffff, 16'd1);
		send_cmd(FUNC_LOOKUP, 16'h5678, 16'd1);
		send_cmd(FUNC_LOOKUP, 16'h4321, 16'd1);
		send_cmd(FUNC_TOTAL, 16'h0000, 16'd1);
		send_cmd(FUNC_COALESCE, 16'h0000, 16'd1);
		send_cmd(FUNC_COMPACT, 16'h0000, 16'd1);
		send_cmd(FUNC_TOTAL, 16'h0000, 16'd1);
		send_cmd(3'd5, 16'haaaa, 16'h5555);
		send_cmd(3'd6, 16'h5555, 16'haaaa);
		send_cmd(3'd7, 16'hffff, 16'hffff);
		repeat (150) random_cmd();

		// random phases under other area sizes
		foreach (areas[k]) begin
			set_area(areas[k]);
			send_cmd(FUNC_COMPACT, 16'h0000, 16'd1);
			send_cmd(FUNC_TOTAL, 16'h0000, 16'd1);
			repeat (150) random_cmd();
		end

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
